>>> design/rfe_crc32_pkg.sv
// Shared types and constants of the receive frame encapsulator.
package rfe_crc32_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 1518;

    localparam int BC_W      = 11;
    localparam int POS_W     = 12;
    localparam int MAC_W     = 48;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 48;
    localparam int IDX_W     = 9;
    localparam int LEN_W     = 16;

    localparam int HDR_GROUPS = 3;
    localparam int PAD_SPAN   = 128;
    localparam int CRC_BYTES  = 4;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [7:0]  MAGIC_0  = 8'hAA;
    localparam logic [7:0]  MAGIC_1  = 8'h55;

    localparam logic [MAC_W-1:0] STATION_MAC_RST = 48'h08002B112233;
    localparam logic [BC_W-1:0]  MIN_WIRE_RST    = 11'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_STATION_MAC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIRE    = 1'd1;

    // request kinds carried on cmd
    localparam logic REQ_EMPTY = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    localparam logic [1:0] HDR_G0 = 2'd0;
    localparam logic [1:0] HDR_G1 = 2'd1;
    localparam logic [1:0] HDR_G2 = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_CRC   = 7'b0000100,
        ST_FLUSH = 7'b0001000,
        ST_HDR0  = 7'b0010000,
        ST_HDR1  = 7'b0100000,
        ST_HDR2  = 7'b1000000
    } rfe_state_t;

    typedef struct packed {
        logic       take_byte;
        logic       take_last;
        logic       take_empty;
        logic       pad_step;
        logic       crc_step;
        logic       flush;
        logic       hdr_emit;
        logic [1:0] hdr_sel;
    } rfe_cmd_t;

    typedef struct packed {
        logic out_free;
        logic byte_ok;
        logic byte_lane3;
        logic pad_needed;
        logic pad_more;
        logic pos_lane3;
        logic crc_last;
    } rfe_status_t;

endpackage

>>> design/rfe_crc32_ctrl.sv
// Sequencing state machine of the receive frame encapsulator.
module rfe_crc32_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      cmd,
    input  logic                      last_byte,
    output logic                      in_stall,
    input  rfe_crc32_pkg::rfe_status_t status,
    output rfe_crc32_pkg::rfe_cmd_t    ctl
);

    rfe_crc32_pkg::rfe_state_t state_reg;
    rfe_crc32_pkg::rfe_state_t state_next;

    logic produce_now;
    logic accept;
    logic step_go;

    // A byte that completes a group needs room in the output register.
    assign produce_now = (cmd == rfe_crc32_pkg::REQ_BYTE) && status.byte_ok && status.byte_lane3;
    assign in_stall    = (state_reg != rfe_crc32_pkg::ST_IDLE)
                         || (produce_now && !status.out_free);
    assign accept      = in_valid && !in_stall;
    assign step_go     = !status.pos_lane3 || status.out_free;

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        ctl.hdr_sel    = rfe_crc32_pkg::HDR_G0;
        unique case (state_reg)
            rfe_crc32_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == rfe_crc32_pkg::REQ_EMPTY)
                    begin
                        ctl.take_empty = 1'b1;
                        state_next     = rfe_crc32_pkg::ST_HDR0;
                    end
                    else
                    begin
                        ctl.take_byte = 1'b1;
                        if (last_byte)
                        begin
                            ctl.take_last = 1'b1;
                            state_next    = status.pad_needed ? rfe_crc32_pkg::ST_PAD
                                                              : rfe_crc32_pkg::ST_CRC;
                        end
                    end
                end
            end
            rfe_crc32_pkg::ST_PAD:
            begin
                if (step_go)
                begin
                    ctl.pad_step = 1'b1;
                    if (!status.pad_more)
                    begin
                        state_next = rfe_crc32_pkg::ST_CRC;
                    end
                end
            end
            rfe_crc32_pkg::ST_CRC:
            begin
                if (step_go)
                begin
                    ctl.crc_step = 1'b1;
                    if (status.crc_last)
                    begin
                        state_next = status.pos_lane3 ? rfe_crc32_pkg::ST_HDR0
                                                      : rfe_crc32_pkg::ST_FLUSH;
                    end
                end
            end
            rfe_crc32_pkg::ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    ctl.flush  = 1'b1;
                    state_next = rfe_crc32_pkg::ST_HDR0;
                end
            end
            rfe_crc32_pkg::ST_HDR0:
            begin
                ctl.hdr_sel = rfe_crc32_pkg::HDR_G0;
                if (status.out_free)
                begin
                    ctl.hdr_emit = 1'b1;
                    state_next   = rfe_crc32_pkg::ST_HDR1;
                end
            end
            rfe_crc32_pkg::ST_HDR1:
            begin
                ctl.hdr_sel = rfe_crc32_pkg::HDR_G1;
                if (status.out_free)
                begin
                    ctl.hdr_emit = 1'b1;
                    state_next   = rfe_crc32_pkg::ST_HDR2;
                end
            end
            rfe_crc32_pkg::ST_HDR2:
            begin
                ctl.hdr_sel = rfe_crc32_pkg::HDR_G2;
                if (status.out_free)
                begin
                    ctl.hdr_emit = 1'b1;
                    state_next   = rfe_crc32_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfe_crc32_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfe_crc32_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/rfe_crc32_dp.sv
// Datapath of the receive frame encapsulator: CRC, group packing, header, output register.
module rfe_crc32_dp #(
    parameter int MAX_FRAME_BYTES = rfe_crc32_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rfe_crc32_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfe_crc32_pkg::CFG_W-1:0]       cfg_data,
    input  logic [7:0]                            data_byte,
    input  logic [7:0]                            queued_count,
    input  rfe_crc32_pkg::rfe_cmd_t                ctl,
    output rfe_crc32_pkg::rfe_status_t             status,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [rfe_crc32_pkg::IDX_W-1:0]       group_index,
    output logic [31:0]                           group_data,
    output logic                                  run_end
);

    localparam int BC_W  = rfe_crc32_pkg::BC_W;
    localparam int POS_W = rfe_crc32_pkg::POS_W;
    localparam int IDX_W = rfe_crc32_pkg::IDX_W;
    localparam int LEN_W = rfe_crc32_pkg::LEN_W;
    localparam logic [BC_W-1:0] MAX_BC = BC_W'(MAX_FRAME_BYTES);

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b_in);
        logic [31:0] c;
        logic [7:0]  b;
        logic        x;
        c = c_in;
        b = b_in;
        for (int k = 0; k < 8; k++)
        begin
            x = b[0] ^ c[0];
            c = c >> 1;
            if (x)
            begin
                c = c ^ rfe_crc32_pkg::CRC_POLY;
            end
            b = b >> 1;
        end
        return c;
    endfunction

    function automatic logic [IDX_W-1:0] grp_index(input logic [POS_W-1:0] p);
        logic [POS_W-3:0] g;
        g = p[POS_W-1:2] + (POS_W-2)'(rfe_crc32_pkg::HDR_GROUPS);
        return g[IDX_W-1:0];
    endfunction

    logic [rfe_crc32_pkg::MAC_W-1:0] mac_reg;
    logic [BC_W-1:0]                 min_wire_reg;
    logic [31:0]                     crc_reg, crc_next;
    logic [BC_W-1:0]                 bc_reg, bc_next;
    logic [23:0]                     partial_reg, partial_next;
    logic [7:0]                      seq_reg, seq_next;
    logic [POS_W-1:0]                pos_reg, pos_next;
    logic [POS_W-1:0]                w_reg, w_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic [7:0]                      q_reg, q_next;
    logic [1:0]                      crc_cnt_reg, crc_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]                out_index_reg, out_index_next;
    logic [31:0]                     out_data_reg, out_data_next;
    logic                            out_end_reg, out_end_next;

    logic             byte_ok;
    logic [BC_W-1:0]  bc_inc;
    logic [POS_W-1:0] bc_new;
    logic [POS_W-1:0] base_lim;
    logic [POS_W-1:0] w_max;
    logic [POS_W-1:0] w_cal;
    logic [POS_W:0]   pos_plus;
    logic [31:0]      crc_fin;
    logic [7:0]       crc_out_byte;

    logic             put_en;
    logic [POS_W-1:0] put_pos;
    logic [7:0]       put_val;
    logic [31:0]      crc_in_sel;
    logic [7:0]       crc_byte_sel;

    assign byte_ok  = bc_reg < MAX_BC;
    assign bc_inc   = byte_ok ? bc_reg + 1'b1 : bc_reg;
    assign bc_new   = POS_W'(bc_inc);
    assign base_lim = POS_W'({bc_reg[BC_W-1:2], 2'b00}) + POS_W'(rfe_crc32_pkg::PAD_SPAN);
    assign w_max    = (POS_W'(min_wire_reg) < bc_new) ? bc_new : POS_W'(min_wire_reg);
    assign w_cal    = (w_max > base_lim) ? base_lim : w_max;
    assign pos_plus = {1'b0, pos_reg} + 1'b1;
    assign crc_fin  = ~crc_reg;

    always_comb
    begin
        case (crc_cnt_reg)
            2'd0:    crc_out_byte = crc_fin[7:0];
            2'd1:    crc_out_byte = crc_fin[15:8];
            2'd2:    crc_out_byte = crc_fin[23:16];
            default: crc_out_byte = crc_fin[31:24];
        endcase
    end

    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.byte_ok    = byte_ok;
    assign status.byte_lane3 = (bc_reg[1:0] == 2'd3);
    assign status.pad_needed = bc_new < w_cal;
    assign status.pad_more   = pos_plus < {1'b0, w_reg};
    assign status.pos_lane3  = (pos_reg[1:0] == 2'd3);
    assign status.crc_last   = (crc_cnt_reg == 2'(rfe_crc32_pkg::CRC_BYTES - 1));

    // Select the byte source for the shared packing and CRC step.
    always_comb
    begin
        put_en       = 1'b0;
        put_pos      = pos_reg;
        put_val      = 8'h00;
        crc_in_sel   = crc_reg;
        crc_byte_sel = 8'h00;
        if (ctl.take_byte && byte_ok)
        begin
            put_en       = 1'b1;
            put_pos      = POS_W'(bc_reg);
            put_val      = data_byte;
            crc_byte_sel = data_byte;
        end
        else if (ctl.pad_step)
        begin
            put_en = 1'b1;
        end
        else if (ctl.crc_step)
        begin
            put_en  = 1'b1;
            put_val = crc_out_byte;
        end
    end

    always_comb
    begin
        crc_next       = crc_reg;
        bc_next        = bc_reg;
        partial_next   = partial_reg;
        seq_next       = seq_reg;
        pos_next       = pos_reg;
        w_next         = w_reg;
        len_next       = len_reg;
        q_next         = q_reg;
        crc_cnt_next   = crc_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_index_next = out_index_reg;
        out_data_next  = out_data_reg;
        out_end_next   = out_end_reg;

        if ((ctl.take_byte && byte_ok) || ctl.pad_step)
        begin
            crc_next = crc_byte(crc_in_sel, crc_byte_sel);
        end
        if (ctl.take_byte)
        begin
            bc_next = bc_inc;
        end

        if (put_en)
        begin
            if (put_pos[1:0] == 2'd3)
            begin
                out_valid_next = 1'b1;
                out_index_next = grp_index(put_pos);
                out_data_next  = {put_val, partial_reg};
                out_end_next   = 1'b0;
                partial_next   = '0;
            end
            else
            begin
                partial_next = partial_reg | (24'(put_val) << {put_pos[1:0], 3'b000});
            end
        end

        if (ctl.pad_step || ctl.crc_step)
        begin
            pos_next = pos_plus[POS_W-1:0];
        end
        if (ctl.crc_step)
        begin
            crc_cnt_next = crc_cnt_reg + 1'b1;
        end

        if (ctl.take_last)
        begin
            pos_next     = bc_new;
            w_next       = w_cal;
            len_next     = LEN_W'(w_cal) + LEN_W'(rfe_crc32_pkg::CRC_BYTES);
            q_next       = queued_count;
            crc_cnt_next = '0;
        end
        if (ctl.take_empty)
        begin
            len_next = '0;
            q_next   = queued_count;
        end

        if (ctl.flush)
        begin
            out_valid_next = 1'b1;
            out_index_next = grp_index(pos_reg);
            out_data_next  = {8'h00, partial_reg};
            out_end_next   = 1'b0;
            partial_next   = '0;
        end

        if (ctl.hdr_emit)
        begin
            out_valid_next = 1'b1;
            out_end_next   = 1'b0;
            case (ctl.hdr_sel)
                rfe_crc32_pkg::HDR_G0:
                begin
                    out_index_next = IDX_W'(0);
                    out_data_next  = {q_reg, seq_reg, rfe_crc32_pkg::MAGIC_1,
                                      rfe_crc32_pkg::MAGIC_0};
                end
                rfe_crc32_pkg::HDR_G1:
                begin
                    out_index_next = IDX_W'(1);
                    out_data_next  = {mac_reg[39:32], mac_reg[47:40],
                                      len_reg[7:0], len_reg[15:8]};
                end
                default:
                begin
                    // Close the run: clear the frame state, advance the sequence.
                    out_index_next = IDX_W'(2);
                    out_data_next  = {mac_reg[7:0], mac_reg[15:8],
                                      mac_reg[23:16], mac_reg[31:24]};
                    out_end_next   = 1'b1;
                    crc_next       = rfe_crc32_pkg::CRC_INIT;
                    bc_next        = '0;
                    partial_next   = '0;
                    seq_next       = seq_reg + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg       <= rfe_crc32_pkg::STATION_MAC_RST;
            min_wire_reg  <= rfe_crc32_pkg::MIN_WIRE_RST;
            crc_reg       <= rfe_crc32_pkg::CRC_INIT;
            bc_reg        <= '0;
            partial_reg   <= '0;
            seq_reg       <= '0;
            pos_reg       <= '0;
            crc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rfe_crc32_pkg::CFG_STATION_MAC: mac_reg      <= cfg_data;
                    rfe_crc32_pkg::CFG_MIN_WIRE:    min_wire_reg <= cfg_data[BC_W-1:0];
                    default:                        ;
                endcase
            end
            crc_reg       <= crc_next;
            bc_reg        <= bc_next;
            partial_reg   <= partial_next;
            seq_reg       <= seq_next;
            pos_reg       <= pos_next;
            crc_cnt_reg   <= crc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        len_reg       <= len_next;
        q_reg         <= q_next;
        out_index_reg <= out_index_next;
        out_data_reg  <= out_data_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid   = out_valid_reg;
    assign group_index = out_index_reg;
    assign group_data  = out_data_reg;
    assign run_end     = out_end_reg;

endmodule

>>> design/rx_frame_encapsulator_crc32_core.sv
// Top level of the receive frame encapsulator with pad and CRC-32 trailer.
//
// Frame bytes enter one request at a time (cmd 1) and are packed into 4-byte
// groups of a buffer image that starts at byte offset 12; each full group is
// sent at once. The block takes the next data byte while a finished group
// still waits in the output register; it holds the input only when a byte
// would complete a group and that register is still occupied. On the last
// byte a sequencer takes over and the input stays stalled until the header
// is out: it appends zero padding up to min_wire_length (one byte per cycle
// unless held by the output register, capped at 128 bytes past the start of
// the group of the last stored byte), then the four CRC-32 bytes least
// significant first, then a partly filled last group if any, then the three
// header groups: magic aa 55, run sequence, queued count, big-endian length
// (padded length plus 4) and the station address. Output stall cycles add
// delay only while a byte that completes a group, the partial last group or
// a header group waits for the output register; padding and CRC bytes that
// do not finish a group keep moving. An empty run (cmd 0) drops any partial
// frame and sends the header alone with length zero. Bytes beyond
// MAX_FRAME_BYTES are dropped, not counted and not put into the CRC;
// last_byte still ends the run. run_end marks the final header group. Write
// configuration only while idle.
module rx_frame_encapsulator_crc32_core #(
    parameter int MAX_FRAME_BYTES = rfe_crc32_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [rfe_crc32_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rfe_crc32_pkg::CFG_W-1:0]     cfg_data,
    // input request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic [7:0]                          data_byte,
    input  logic                                last_byte,
    input  logic [7:0]                          queued_count,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rfe_crc32_pkg::IDX_W-1:0]     group_index,
    output logic [31:0]                         group_data,
    output logic                                run_end
);

    rfe_crc32_pkg::rfe_cmd_t    ctl;
    rfe_crc32_pkg::rfe_status_t status;

    // Sequence accept, padding, CRC trailer and header emission.
    rfe_crc32_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .last_byte (last_byte),
        .in_stall  (in_stall),
        .status    (status),
        .ctl       (ctl)
    );

    // Hold configuration, CRC and packing state; drive the output register.
    rfe_crc32_dp #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (data_byte),
        .queued_count (queued_count),
        .ctl          (ctl),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .group_index  (group_index),
        .group_data   (group_data),
        .run_end      (run_end)
    );

endmodule
